// ----- design/dvp_pkg.sv -----
// Shared types and constants for the drive velocity profile block.
package dvp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ACCEL  = 2'd1,
		PH_CRUISE = 2'd2,
		PH_DECEL  = 2'd3
	} phase_t;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned RAMP_W  = 9;
	localparam int unsigned SPEED_W = 8;

	localparam logic [LEN_W-1:0]   SHORT_MOVE = 16'd500;
	localparam logic [RAMP_W-1:0]  RAMP_MAX   = 9'd250;
	localparam logic [SPEED_W-1:0] FULL_SPEED = 8'd200;
	localparam logic [SPEED_W-1:0] BASE_SPEED = 8'd50;

	// 3/1250 as a reciprocal scaled by 2^28; exact for every square below 2^16.
	localparam int unsigned   ACC_SHIFT = 28;
	localparam logic [19:0]   ACC_RECIP = 20'd644247;
	// 1/5 scaled by 2^10; exact for operands up to 1023.
	localparam int unsigned   DIV5_SHIFT = 10;
	localparam logic [7:0]    DIV5_RECIP = 8'd205;

	typedef struct packed {
		logic [POS_W-1:0]  start_position;
		logic [LEN_W-1:0]  move_length;
		logic [RAMP_W-1:0] ramp_length;
		phase_t            motion_phase;
	} dvp_state_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		phase_t             phase;
		logic               done_res;
	} dvp_result_t;

endpackage

// ----- design/dvp_if.sv -----
// Valid/ready channel interfaces for profile inputs and speed results.
interface dvp_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [31:0] position;
	logic [15:0]        distance;

	modport source (output valid, output cmd, output position, output distance, input ready);
	modport sink (input valid, input cmd, input position, input distance, output ready);
endinterface

interface dvp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] speed;
	logic [1:0] phase;
	logic       done_res;

	modport source (output valid, output speed, output phase, output done_res, input ready);
	modport sink (input valid, input speed, input phase, input done_res, output ready);
endinterface

// ----- design/dvp_profile_eval.sv -----
// Combinational evaluation of one profile transaction against the current motion state.
module dvp_profile_eval (
	input  logic                     cmd,
	input  logic [31:0]              position,
	input  logic [15:0]              distance,
	input  dvp_pkg::dvp_state_t      cur,
	output dvp_pkg::dvp_state_t      nxt,
	output dvp_pkg::dvp_result_t     res
);
	import dvp_pkg::*;

	logic signed [32:0] delta;
	logic [31:0]        dist_done;
	logic signed [33:0] remain;
	logic signed [33:0] ramp_ext;
	logic signed [33:0] diff;
	logic [15:0]        square;
	logic [35:0]        acc_prod;
	logic [7:0]         acc_speed;
	logic [9:0]         dec_num;
	logic [17:0]        dec_prod;
	logic [7:0]         dec_speed;
	phase_t             ph;

	assign delta     = $signed({position[31], position}) -
		$signed({cur.start_position[31], cur.start_position});
	assign dist_done = delta[32] ? 32'(-delta) : delta[31:0];
	assign remain    = $signed({18'd0, cur.move_length}) - $signed({2'd0, dist_done});
	assign ramp_ext  = $signed({25'd0, cur.ramp_length});
	assign diff      = ramp_ext - remain;

	assign square    = dist_done[7:0] * dist_done[7:0];
	assign acc_prod  = 36'(square) * 36'(ACC_RECIP);
	assign acc_speed = acc_prod[ACC_SHIFT +: 8] + BASE_SPEED;

	// Ramp-down speed is 200 - ceil(4*diff/5), with diff below 250 whenever it is used.
	assign dec_num   = {diff[7:0], 2'b00} + 10'd4;
	assign dec_prod  = 18'(dec_num) * 18'(DIV5_RECIP);
	assign dec_speed = (diff <= 0) ? FULL_SPEED : FULL_SPEED - dec_prod[DIV5_SHIFT +: 8];

	always_comb begin
		nxt = cur;
		res = '{speed: '0, phase: PH_IDLE, done_res: 1'b0};
		ph  = cur.motion_phase;
		if (cmd == CMD_START) begin
			nxt.start_position = position;
			nxt.move_length    = distance;
			nxt.ramp_length    = (distance < SHORT_MOVE) ? {1'b0, distance[8:1]} : RAMP_MAX;
			nxt.motion_phase   = PH_ACCEL;
			res.phase          = PH_ACCEL;
		end else if (cur.motion_phase != PH_IDLE) begin
			if (ph == PH_ACCEL) begin
				if (dist_done < {23'd0, cur.ramp_length}) begin
					res.speed = acc_speed;
				end else begin
					ph = PH_CRUISE;
				end
			end
			if (ph == PH_CRUISE) begin
				if (remain > ramp_ext) begin
					res.speed = FULL_SPEED;
				end else begin
					ph = PH_DECEL;
				end
			end
			if (ph == PH_DECEL) begin
				if (remain > 0) begin
					res.speed = dec_speed;
				end else begin
					res.speed    = '0;
					res.done_res = 1'b1;
					ph           = PH_IDLE;
				end
			end
			nxt.motion_phase = ph;
			res.phase        = ph;
		end
	end

endmodule

// ----- design/drive_velocity_profile.sv -----
// Drive velocity profile: an accepted transaction passes through the input register, then the
// profile evaluation, then the result register. Throughput is one transaction per cycle while
// results are taken without back-pressure, and the motion state updates in step with the result register.
// The input register lets a new transaction in while a result waits to be taken.
// Reset clears the motion state to idle with zero start position, length and ramp.
module drive_velocity_profile (
	input logic       clk,
	input logic       arst_n,
	dvp_in_if.sink    item,
	dvp_out_if.source result
);
	import dvp_pkg::*;

	logic        valid_s1;
	logic        cmd_s1;
	logic [31:0] position_s1;
	logic [15:0] distance_s1;
	logic        valid_q;
	dvp_result_t result_q;
	dvp_state_t  state_q;
	dvp_state_t  state_nxt;
	dvp_result_t result_nxt;
	logic        advance;

	assign advance    = valid_s1 && (!valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1      <= item.cmd;
			position_s1 <= item.position;
			distance_s1 <= item.distance;
		end
	end

	dvp_profile_eval u_eval (
		.cmd      (cmd_s1),
		.position (position_s1),
		.distance (distance_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			state_q <= '{start_position: '0, move_length: '0, ramp_length: '0,
				motion_phase: PH_IDLE};
		end else if (advance) begin
			valid_q <= 1'b1;
			state_q <= state_nxt;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result.valid    = valid_q;
	assign result.speed    = result_q.speed;
	assign result.phase    = result_q.phase;
	assign result.done_res = result_q.done_res;

endmodule

// ----- tb/drive_velocity_profile_test.sv -----
// Self-checking testbench for the drive velocity profile: a directed table, then random moves.
module drive_velocity_profile_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dvp_pkg::*;

	typedef struct {
		logic               cmd;
		logic signed [31:0] position;
		logic [15:0]        distance;
		bit                 typed;
		dvp_result_t        result;
	} move_cmd_t;

	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_ITEMS  = 1430;

	logic clk = 1'b0;
	logic arst_n;

	dvp_in_if  item_ch();
	dvp_out_if result_ch();

	drive_velocity_profile uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always #1 clk = ~clk;

	// Rows with typed set carry a result that is obvious from the profile definition.
	move_cmd_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_SAMPLE, 32'sd0, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sh7FFFFFFF, 16'hFFFF, 1'b1, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_START, 32'sd0, 16'd1000, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sd0, 16'd0, 1'b1, '{8'd50, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sd100, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, -32'sd249, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sd250, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sd800, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sd600, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sd1000, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b1}},
		'{CMD_SAMPLE, 32'sd1000, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_START, 32'sh80000000, 16'd0, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sh80000000, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b1}},
		'{CMD_START, 32'sh7FFFFFFF, 16'hFFFF, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sh80000000, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b1}},
		'{CMD_START, 32'sd5, 16'd499, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sd5, 16'd0, 1'b1, '{8'd50, PH_ACCEL, 1'b0}},
		'{CMD_START, -32'sd1000, 16'd500, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, -32'sd700, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, -32'sd501, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_START, 32'sd0, 16'd1, 1'b1, '{8'd0, PH_ACCEL, 1'b0}},
		'{CMD_SAMPLE, 32'sd0, 16'd0, 1'b0, '{8'd0, PH_IDLE, 1'b0}},
		'{CMD_SAMPLE, 32'sd1, 16'd0, 1'b1, '{8'd0, PH_IDLE, 1'b1}}
	};

	move_cmd_t   profile_items[$];
	dvp_result_t speed_cmds_due[$];
	int          mismatches = 0;

	logic signed [31:0] latched_pos = '0;
	logic [15:0]        latched_len = '0;
	logic [8:0]         ramp_len = '0;
	phase_t             cur_phase = PH_IDLE;

	function automatic dvp_result_t predict_speed(logic cmd, logic signed [31:0] position,
			logic [15:0] distance);
		dvp_result_t r;
		longint travel;
		longint remain;
		longint ramp;
		longint slope;
		longint spd;
		spd = 0;
		r.done_res = 1'b0;
		if (cmd == CMD_START) begin
			latched_pos = position;
			latched_len = distance;
			ramp_len = (distance < SHORT_MOVE) ? distance[9:1] : RAMP_MAX;
			cur_phase = PH_ACCEL;
		end else if (cur_phase != PH_IDLE) begin
			travel = longint'(position) - longint'(latched_pos);
			if (travel < 0) begin
				travel = -travel;
			end
			ramp = longint'(ramp_len);
			remain = longint'(latched_len) - travel;
			if (cur_phase == PH_ACCEL) begin
				if (travel < ramp) begin
					spd = (3 * travel * travel) / 1250 + longint'(BASE_SPEED);
				end else begin
					cur_phase = PH_CRUISE;
				end
			end
			if (cur_phase == PH_CRUISE) begin
				if (remain > ramp) begin
					spd = longint'(FULL_SPEED);
				end else begin
					cur_phase = PH_DECEL;
				end
			end
			if (cur_phase == PH_DECEL) begin
				if (remain > 0) begin
					slope = ramp - remain;
					if (slope <= 0) begin
						spd = longint'(FULL_SPEED);
					end else if (slope > 1000) begin
						spd = 0;
					end else begin
						spd = longint'(FULL_SPEED) - (4 * slope + 4) / 5;
						if (spd < 0) begin
							spd = 0;
						end
					end
				end else begin
					spd = 0;
					r.done_res = 1'b1;
					cur_phase = PH_IDLE;
				end
			end
		end
		r.speed = spd[7:0];
		r.phase = cur_phase;
		return r;
	endfunction

	function automatic void plan_random_moves();
		move_cmd_t m;
		logic signed [31:0] origin;
		int length;
		int travel;
		int step_max;
		int step;
		int samples;
		int sample_cap;
		int kind;
		int sel;
		bit backward;
		m.typed = 1'b0;
		m.result = '0;
		while (profile_items.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			origin = $urandom;
			if (kind == 0) begin
				m.cmd = 1'($urandom_range(0, 1));
				m.position = $urandom;
				m.distance = 16'($urandom);
				profile_items.push_back(m);
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					length = $urandom_range(0, 1200);
				end else if (sel < 9) begin
					length = $urandom_range(0, 40);
				end else begin
					length = $urandom_range(0, 65535);
				end
				m.cmd = CMD_START;
				m.position = origin;
				m.distance = 16'(length);
				profile_items.push_back(m);
				backward = 1'($urandom_range(0, 1));
				step_max = length / 12 + 2;
				sample_cap = (kind == 1) ? $urandom_range(1, 4) : 40;
				travel = 0;
				samples = 0;
				while (travel <= length && samples < sample_cap) begin
					step = $urandom_range(0, step_max);
					if ($urandom_range(0, 9) == 0) begin
						travel -= step;
					end else begin
						travel += step;
					end
					m.cmd = CMD_SAMPLE;
					m.position = backward ? origin - travel : origin + travel;
					m.distance = 16'($urandom);
					profile_items.push_back(m);
					samples++;
				end
				if (kind != 1 && travel <= length) begin
					travel = length + $urandom_range(0, 3);
					m.position = backward ? origin - travel : origin + travel;
					profile_items.push_back(m);
				end
			end
		end
	endfunction

	task automatic report_mismatch(int index, string field, int got, int want);
		mismatches++;
		$display("ERROR: result transaction %0d: %s is %0d, expected %0d",
			index, field, got, want);
	endtask

	initial begin
		move_cmd_t m;
		dvp_result_t want;
		bit calm;
		int gap;
		arst_n = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_SAMPLE;
		item_ch.position <= '0;
		item_ch.distance <= '0;
		foreach (directed_rows[i]) begin
			profile_items.push_back(directed_rows[i]);
		end
		plan_random_moves();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		calm = 1'b0;
		foreach (profile_items[i]) begin
			m = profile_items[i];
			if ($urandom_range(0, 39) == 0) begin
				calm = ~calm;
			end
			gap = calm ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_ch.valid <= 1'b1;
			item_ch.cmd <= m.cmd;
			item_ch.position <= m.position;
			item_ch.distance <= m.distance;
			@(posedge clk);
			while (item_ch.ready !== 1'b1) @(posedge clk);
			want = predict_speed(m.cmd, m.position, m.distance);
			if (m.typed) begin
				want = m.result;
			end
			speed_cmds_due.push_back(want);
		end
		item_ch.valid <= 1'b0;
		while (speed_cmds_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		dvp_result_t want;
		bit calm;
		int gap;
		int seen;
		result_ch.ready <= 1'b0;
		calm = 1'b0;
		seen = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				calm = ~calm;
			end
			gap = calm ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			if (speed_cmds_due.size() == 0) begin
				report_mismatch(seen, "unexpected transaction, speed",
					int'(result_ch.speed), 0);
			end else begin
				want = speed_cmds_due.pop_front();
				if (result_ch.speed !== want.speed) begin
					report_mismatch(seen, "speed", int'(result_ch.speed), int'(want.speed));
				end
				if (result_ch.phase !== want.phase) begin
					report_mismatch(seen, "phase", int'(result_ch.phase), int'(want.phase));
				end
				if (result_ch.done_res !== want.done_res) begin
					report_mismatch(seen, "done_res", int'(result_ch.done_res),
						int'(want.done_res));
				end
			end
			seen++;
		end
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
